### rtl/core/ccr_pkg.sv
// Shared types and constants for the circle collision resolver pipeline.
package ccr_pkg;

	localparam int unsigned ROOT_W = 19;   // root, radius sum, penetration
	localparam int unsigned SQ_W   = 38;   // |D|^2 bits that matter on a hit
	localparam int unsigned REM_W  = 23;   // square root partial remainder
	localparam int unsigned NUM_W  = 40;   // |Dc| * pen

	typedef struct packed {
		logic signed [19:0] center_a_x;
		logic signed [19:0] center_a_y;
		logic signed [19:0] center_b_x;
		logic signed [19:0] center_b_y;
		logic        [17:0] radius_a;
		logic        [17:0] radius_b;
		logic               immovable_a;
		logic               immovable_b;
		logic               both_circles;
	} pair_t;

	typedef struct packed {
		logic               hit;
		logic signed [19:0] push_a_x;
		logic signed [19:0] push_a_y;
		logic signed [19:0] push_b_x;
		logic signed [19:0] push_b_y;
	} result_t;

	// beat handed from the distance stages to the square root
	typedef struct packed {
		logic               hit;
		logic signed [20:0] dx;
		logic signed [20:0] dy;
		logic [SQ_W-1:0]    sq;
		logic [ROOT_W-1:0]  rad;
		logic               imm_a;
		logic               imm_b;
	} dist_t;

	// beat handed from the square root to the divider
	typedef struct packed {
		logic               hit;
		logic signed [20:0] dx;
		logic signed [20:0] dy;
		logic [ROOT_W-1:0]  d;
		logic [ROOT_W-1:0]  rad;
		logic               imm_a;
		logic               imm_b;
	} root_t;

endpackage

### rtl/core/circle_collision_resolver.sv
// Top level of the circle collision resolver.
// Usage:
//   pair channel: pair_valid / pair_stall / pair, one collider pair per beat.
//   res channel:  res_valid / res_stall / res, one result beat per pair beat,
//   in the order the pairs came in.
//   A result holds the overlap flag and the four push components; a miss
//   or coincident centers give zero pushes.
// Stages: 3 distance stages, 19 square root stages, 1 multiply stage,
//   19 divide stages and 1 output stage, each root and quotient bit costing one stage.
// Throughput: one pair per cycle sustained while res is not stalled.
// Stall: each stage holds its beat only when it is full and the stage after
//   it cannot take a beat, so empty stages keep filling while res is stalled;
//   pair_stall rises only once the whole pipeline is full.
// Reset: arst_n clears all stage valid bits; the pipeline comes up empty.
module circle_collision_resolver
	import ccr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pair_valid,
	output logic    pair_stall,
	input  pair_t   pair,
	output logic    res_valid,
	input  logic    res_stall,
	output result_t res
);

	logic  dist_valid, dist_stall, root_valid, root_stall;
	dist_t dist_beat;
	root_t root;

	ccr_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pair_valid),
		.up_stall (pair_stall),
		.up_data  (pair),
		.dn_valid (dist_valid),
		.dn_stall (dist_stall),
		.dn_data  (dist_beat)
	);

	ccr_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (dist_valid),
		.up_stall (dist_stall),
		.up_data  (dist_beat),
		.dn_valid (root_valid),
		.dn_stall (root_stall),
		.dn_data  (root)
	);

	ccr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (root_valid),
		.up_stall (root_stall),
		.up_data  (root),
		.dn_valid (res_valid),
		.dn_stall (res_stall),
		.dn_data  (res)
	);

endmodule

### rtl/core/ccr_prep.sv
// Difference vector, squares and overlap test in three pipeline stages.
module ccr_prep
	import ccr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_stall,
	input  pair_t up_data,
	output logic  dn_valid,
	input  logic  dn_stall,
	output dist_t dn_data
);

	logic               v_s1, v_s2, v_s3;
	logic               rdy1, rdy2, rdy3;
	logic signed [20:0] dx_s1, dy_s1, dx_s2, dy_s2;
	logic [ROOT_W-1:0]  rad_s1, rad_s2;
	logic               circ_s1, circ_s2, ia_s1, ia_s2, ib_s1, ib_s2;
	logic [40:0]        dx2_s2, dy2_s2;
	logic [37:0]        rad2_s2;
	logic signed [41:0] pdx, pdy;
	logic [41:0]        sum;
	dist_t              out_s3;

	assign rdy3     = !v_s3 || !dn_stall;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign up_stall = !rdy1;
	assign dn_valid = v_s3;
	assign dn_data  = out_s3;

	assign pdx = dx_s1 * dx_s1;
	assign pdy = dy_s1 * dy_s1;
	assign sum = {1'b0, dx2_s2} + {1'b0, dy2_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= up_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			dx_s1   <= 21'(up_data.center_b_x) - 21'(up_data.center_a_x);
			dy_s1   <= 21'(up_data.center_b_y) - 21'(up_data.center_a_y);
			rad_s1  <= {1'b0, up_data.radius_a} + {1'b0, up_data.radius_b};
			circ_s1 <= up_data.both_circles;
			ia_s1   <= up_data.immovable_a;
			ib_s1   <= up_data.immovable_b;
		end
		if (rdy2) begin
			dx2_s2  <= pdx[40:0];
			dy2_s2  <= pdy[40:0];
			rad2_s2 <= 38'(rad_s1) * 38'(rad_s1);
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			rad_s2  <= rad_s1;
			circ_s2 <= circ_s1;
			ia_s2   <= ia_s1;
			ib_s2   <= ib_s1;
		end
		if (rdy3) begin
			out_s3.hit   <= circ_s2 && (sum <= {4'b0, rad2_s2});
			out_s3.dx    <= dx_s2;
			out_s3.dy    <= dy_s2;
			out_s3.sq    <= sum[SQ_W-1:0];  // upper bits only matter on a miss
			out_s3.rad   <= rad_s2;
			out_s3.imm_a <= ia_s2;
			out_s3.imm_b <= ib_s2;
		end
	end

endmodule

### rtl/core/ccr_sqrt.sv
// Integer square root, one result bit per pipeline stage.
module ccr_sqrt
	import ccr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_stall,
	input  dist_t up_data,
	output logic  dn_valid,
	input  logic  dn_stall,
	output root_t dn_data
);

	localparam int unsigned N = ROOT_W;

	logic [N-1:0]      v_s;
	logic [N:0]        rdy;
	dist_t             pay_s  [N];
	logic [REM_W-1:0]  rem_s  [N];
	logic [ROOT_W-1:0] root_s [N];

	assign rdy[N]   = !dn_stall;
	assign up_stall = !rdy[0];
	assign dn_valid = v_s[N-1];

	always_comb begin
		dn_data.hit   = pay_s[N-1].hit;
		dn_data.dx    = pay_s[N-1].dx;
		dn_data.dy    = pay_s[N-1].dy;
		dn_data.d     = root_s[N-1];
		dn_data.rad   = pay_s[N-1].rad;
		dn_data.imm_a = pay_s[N-1].imm_a;
		dn_data.imm_b = pay_s[N-1].imm_b;
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam int unsigned B = 2 * (N - 1 - k);
		logic              vin;
		dist_t             pin;
		logic [REM_W-1:0]  rin, rsh, trial;
		logic [ROOT_W-1:0] qin;

		assign rdy[k] = !v_s[k] || rdy[k+1];

		if (k == 0) begin : g_first
			assign vin = up_valid;
			assign pin = up_data;
			assign rin = '0;
			assign qin = '0;
		end else begin : g_next
			assign vin = v_s[k-1];
			assign pin = pay_s[k-1];
			assign rin = rem_s[k-1];
			assign qin = root_s[k-1];
		end

		assign rsh   = {rin[REM_W-3:0], pin.sq[B+1:B]};
		assign trial = {{(REM_W-2-ROOT_W){1'b0}}, qin, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				pay_s[k] <= pin;
				if (rsh >= trial) begin
					rem_s[k]  <= rsh - trial;
					root_s[k] <= {qin[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k]  <= rsh;
					root_s[k] <= {qin[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

endmodule

### rtl/core/ccr_div.sv
// Penetration scaling: multiply, restoring divide by d, push selection.
module ccr_div
	import ccr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    up_valid,
	output logic    up_stall,
	input  root_t   up_data,
	output logic    dn_valid,
	input  logic    dn_stall,
	output result_t dn_data
);

	localparam int unsigned N = ROOT_W;  // quotient bits, at most pen on a hit

	typedef struct packed {
		logic              hit;
		logic              nz;   // nonzero distance, pushes apply
		logic              sx;
		logic              sy;
		logic              imm_a;
		logic              imm_b;
		logic [ROOT_W-1:0] d;
	} ctl_t;

	// multiply stage
	logic              v_s1;
	ctl_t              ctl_s1;
	logic [NUM_W-1:0]  mx_s1, my_s1;
	logic [20:0]       ax, ay;
	logic [ROOT_W-1:0] pen;

	// divide stages
	logic [N-1:0]      v_s;
	logic [N+1:0]      rdy;
	ctl_t              ctl_s [N];
	logic [NUM_W-1:0]  mx_s  [N];
	logic [NUM_W-1:0]  my_s  [N];
	logic [ROOT_W-1:0] rx_s  [N];
	logic [ROOT_W-1:0] ry_s  [N];
	logic [N-1:0]      qx_s  [N];
	logic [N-1:0]      qy_s  [N];

	// output stage
	logic    v_out;
	result_t res_out;
	ctl_t    cf;
	logic [19:0] fx, fy, hx, hy, vx, vy;

	assign ax  = up_data.dx[20] ? 21'(-up_data.dx) : 21'(up_data.dx);
	assign ay  = up_data.dy[20] ? 21'(-up_data.dy) : 21'(up_data.dy);
	assign pen = up_data.rad - up_data.d;

	assign rdy[N+1]  = !v_out || !dn_stall;
	assign rdy[0]    = !v_s1 || rdy[1];
	assign up_stall  = !rdy[0];
	assign dn_valid  = v_out;
	assign dn_data   = res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_out <= 1'b0;
		end else begin
			if (rdy[0])   v_s1  <= up_valid;
			if (rdy[N+1]) v_out <= v_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			mx_s1        <= NUM_W'(ax) * NUM_W'(pen);
			my_s1        <= NUM_W'(ay) * NUM_W'(pen);
			ctl_s1.hit   <= up_data.hit;
			ctl_s1.nz    <= (up_data.d != '0);
			ctl_s1.sx    <= up_data.dx[20];
			ctl_s1.sy    <= up_data.dy[20];
			ctl_s1.imm_a <= up_data.imm_a;
			ctl_s1.imm_b <= up_data.imm_b;
			ctl_s1.d     <= up_data.d;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam int unsigned J = N - 1 - k;
		logic              vin;
		ctl_t              cin;
		logic [NUM_W-1:0]  xin, yin;
		logic [ROOT_W-1:0] rxi, ryi;
		logic [N-1:0]      qxi, qyi;
		logic [ROOT_W:0]   tx, ty, dd;

		assign rdy[k+1] = !v_s[k] || rdy[k+2];

		if (k == 0) begin : g_first
			// numerator >> N stays below d when the pair hits at nonzero distance
			assign vin = v_s1;
			assign cin = ctl_s1;
			assign xin = mx_s1;
			assign yin = my_s1;
			assign rxi = mx_s1[N+ROOT_W-1:N];
			assign ryi = my_s1[N+ROOT_W-1:N];
			assign qxi = '0;
			assign qyi = '0;
		end else begin : g_next
			assign vin = v_s[k-1];
			assign cin = ctl_s[k-1];
			assign xin = mx_s[k-1];
			assign yin = my_s[k-1];
			assign rxi = rx_s[k-1];
			assign ryi = ry_s[k-1];
			assign qxi = qx_s[k-1];
			assign qyi = qy_s[k-1];
		end

		assign tx = {rxi, xin[J]};
		assign ty = {ryi, yin[J]};
		assign dd = {1'b0, cin.d};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k+1]) begin
				v_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k+1]) begin
				ctl_s[k] <= cin;
				mx_s[k]  <= xin;
				my_s[k]  <= yin;
				if (tx >= dd) begin
					rx_s[k] <= ROOT_W'(tx - dd);
					qx_s[k] <= qxi | (N'(1) << J);
				end else begin
					rx_s[k] <= ROOT_W'(tx);
					qx_s[k] <= qxi;
				end
				if (ty >= dd) begin
					ry_s[k] <= ROOT_W'(ty - dd);
					qy_s[k] <= qyi | (N'(1) << J);
				end else begin
					ry_s[k] <= ROOT_W'(ty);
					qy_s[k] <= qyi;
				end
			end
		end
	end

	// half split is floor of the full quotient over two
	assign cf = ctl_s[N-1];
	assign fx = {1'b0, qx_s[N-1]};
	assign fy = {1'b0, qy_s[N-1]};
	assign hx = {2'b0, qx_s[N-1][N-1:1]};
	assign hy = {2'b0, qy_s[N-1][N-1:1]};
	assign vx = cf.imm_a || cf.imm_b ? fx : hx;
	assign vy = cf.imm_a || cf.imm_b ? fy : hy;

	always_ff @(posedge clk) begin
		if (rdy[N+1]) begin
			res_out.hit <= cf.hit;
			res_out.push_a_x <= '0;
			res_out.push_a_y <= '0;
			res_out.push_b_x <= '0;
			res_out.push_b_y <= '0;
			if (cf.hit && cf.nz) begin
				if (!cf.imm_a) begin
					res_out.push_a_x <= cf.sx ? vx : 20'(-vx);
					res_out.push_a_y <= cf.sy ? vy : 20'(-vy);
				end
				if (cf.imm_a || !cf.imm_b) begin
					res_out.push_b_x <= cf.sx ? 20'(-vx) : vx;
					res_out.push_b_y <= cf.sy ? 20'(-vy) : vy;
				end
			end
		end
	end

endmodule

### rtl/core/ccr_checker.sv
// Port-level checks for the circle collision resolver, bound to the top level.
module ccr_checker
	import ccr_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    res_valid,
	input logic    res_stall,
	input result_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result beat changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.hit |-> res.push_a_x == '0 && res.push_a_y == '0 &&
			res.push_b_x == '0 && res.push_b_y == '0)
		else $error("miss carries a nonzero push");

	a_split_x: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.hit |-> res.push_a_x == '0 || res.push_b_x == '0 ||
			res.push_a_x == 20'(-res.push_b_x))
		else $error("x pushes are not opposite");

	a_split_y: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.hit |-> res.push_a_y == '0 || res.push_b_y == '0 ||
			res.push_a_y == 20'(-res.push_b_y))
		else $error("y pushes are not opposite");

endmodule

bind circle_collision_resolver ccr_checker u_ccr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
